[hdl/launch_engage_retry_guard_unit_macros.svh]
// Assertion helpers shared by the guard RTL.
// LERG_ASSERT    : clocked check, disabled while reset is asserted.
// LERG_ASSERT_RST: clocked check that also holds during reset.
`ifndef LAUNCH_ENGAGE_RETRY_GUARD_UNIT_MACROS_SVH
`define LAUNCH_ENGAGE_RETRY_GUARD_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LERG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("guard assertion failed");
`define LERG_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("guard assertion failed");
`else
`define LERG_ASSERT(label, clk, rst_n, prop)
`define LERG_ASSERT_RST(label, clk, prop)
`endif

`endif

[hdl/lerg_pkg.sv]
package lerg_pkg;

    // Default parameter values
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int SPEED_WIDTH_DEF = 16;

    // Configuration register widths
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 15;

    // Configuration reset values
    localparam logic              GUARD_ENABLE_RST    = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RETRY_PERIOD_RST  = 32'd500;
    localparam logic [CFG_DATA_W-1:0] RETRY_TIMEOUT_RST = 32'd5000;
    localparam logic [THR_W-1:0]  SPEED_THRESHOLD_RST = 15'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GUARD_ENABLE    = 2'd0,
        CFG_RETRY_PERIOD    = 2'd1,
        CFG_RETRY_TIMEOUT   = 2'd2,
        CFG_SPEED_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_REPORT = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_READY = 2'd1,
        KIND_START = 2'd2,
        KIND_RESET = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_AWAIT     = 2'd1,
        PH_CONFIRMED = 2'd2,
        PH_TIMEOUT   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_READY   = 3'd1,
        EV_START   = 3'd2,
        EV_RETRY   = 3'd3,
        EV_MOTION  = 3'd4,
        EV_TIMEOUT = 3'd5,
        EV_RESET   = 3'd6
    } t_event;

    // Reported phase code when the guard is disabled
    localparam logic [2:0] PO_DISABLED = 3'd0;

    typedef struct packed {
        logic                  guard_enable;
        logic [CFG_DATA_W-1:0] retry_period;
        logic [CFG_DATA_W-1:0] retry_timeout;
        logic [THR_W-1:0]      speed_threshold;
    } t_cfg;

    // State update controls from the decision logic
    typedef struct packed {
        t_phase phase_nxt;
        logic   load_start;
        logic   load_last;
        logic   clr_times;
    } t_ctl;

    typedef struct packed {
        t_event     event_res;
        logic       send_request;
        logic       suppress_recovery;
        logic [2:0] phase_out;
    } t_result;

    // Externally reported phase: stored phase shifted past the disabled code
    function automatic logic [2:0] phase_code(input t_phase p);
        phase_code = {1'b0, p} + 3'd1;
    endfunction

endpackage

[hdl/lerg_cfg_regs.sv]
module lerg_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lerg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lerg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lerg_pkg::t_cfg                 o_cfg
);
    import lerg_pkg::*;

    t_cfg r_cfg;

    // Register file write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.guard_enable    <= GUARD_ENABLE_RST;
            r_cfg.retry_period    <= RETRY_PERIOD_RST;
            r_cfg.retry_timeout   <= RETRY_TIMEOUT_RST;
            r_cfg.speed_threshold <= SPEED_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GUARD_ENABLE:    r_cfg.guard_enable    <= i_cfg_data[0];
                CFG_RETRY_PERIOD:    r_cfg.retry_period    <= i_cfg_data;
                CFG_RETRY_TIMEOUT:   r_cfg.retry_timeout   <= i_cfg_data;
                CFG_SPEED_THRESHOLD: r_cfg.speed_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/lerg_decide.sv]
module lerg_decide #(
    parameter int TIME_WIDTH  = lerg_pkg::TIME_WIDTH_DEF,
    parameter int SPEED_WIDTH = lerg_pkg::SPEED_WIDTH_DEF
) (
    input  lerg_pkg::t_cfg            i_cfg,
    input  lerg_pkg::t_cmd            i_cmd,
    input  lerg_pkg::t_kind           i_kind,
    input  logic [TIME_WIDTH-1:0]     i_now,
    input  logic                      i_time_valid,
    input  logic [SPEED_WIDTH-1:0]    i_speed,
    input  logic                      i_speed_valid,
    input  lerg_pkg::t_phase          i_phase,
    input  logic [TIME_WIDTH-1:0]     i_start_time,
    input  logic [TIME_WIDTH-1:0]     i_last_time,
    output lerg_pkg::t_ctl            o_ctl,
    output lerg_pkg::t_result         o_res
);
    import lerg_pkg::*;

    localparam int CmpTw = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;
    localparam int CmpSw = (SPEED_WIDTH > THR_W) ? SPEED_WIDTH : THR_W;

    logic [TIME_WIDTH-1:0]  since_start;
    logic [TIME_WIDTH-1:0]  since_last;
    logic [SPEED_WIDTH-1:0] speed_mag;
    logic                   motion_hit;
    logic                   timed_out;
    logic                   retry_due;

    // Magnitude as unsigned: the most negative value stays exact
    assign speed_mag  = i_speed[SPEED_WIDTH-1] ? (~i_speed + 1'b1) : i_speed;
    assign motion_hit = CmpSw'(speed_mag) >= CmpSw'(i_cfg.speed_threshold);

    // Elapsed-time checks; time running backwards is caught first
    assign since_start = i_now - i_start_time;
    assign since_last  = i_now - i_last_time;
    assign timed_out   = (i_now < i_start_time) ||
                         (CmpTw'(since_start) >= CmpTw'(i_cfg.retry_timeout));
    assign retry_due   = (i_now < i_last_time) ||
                         (CmpTw'(since_last) >= CmpTw'(i_cfg.retry_period));

    // Next state and result for one item
    always_comb begin
        o_ctl.phase_nxt        = i_phase;
        o_ctl.load_start       = 1'b0;
        o_ctl.load_last        = 1'b0;
        o_ctl.clr_times        = 1'b0;
        o_res.event_res         = EV_NONE;
        o_res.send_request      = 1'b0;
        o_res.suppress_recovery = 1'b0;
        o_res.phase_out         = phase_code(i_phase);

        if (!i_cfg.guard_enable) begin
            o_ctl.phase_nxt = PH_IDLE;
            o_ctl.clr_times = 1'b1;
            o_res.phase_out = PO_DISABLED;
        end else if (i_cmd == CMD_REPORT) begin
            if (i_time_valid) begin
                unique case (i_kind) inside
                    KIND_READY, KIND_START: begin
                        o_ctl.phase_nxt         = PH_AWAIT;
                        o_ctl.load_start        = 1'b1;
                        o_ctl.load_last         = 1'b1;
                        o_res.event_res         = (i_kind == KIND_READY) ? EV_READY : EV_START;
                        o_res.send_request      = 1'b1;
                        o_res.suppress_recovery = 1'b1;
                        o_res.phase_out         = phase_code(PH_AWAIT);
                    end
                    KIND_RESET: begin
                        o_ctl.phase_nxt = PH_IDLE;
                        o_ctl.clr_times = 1'b1;
                        o_res.event_res = (i_phase != PH_IDLE) ? EV_RESET : EV_NONE;
                        o_res.phase_out = phase_code(PH_IDLE);
                    end
                    default: begin
                        o_res.suppress_recovery = (i_phase == PH_AWAIT);
                    end
                endcase
            end
        end else if (i_phase == PH_AWAIT) begin
            if (!i_time_valid || !i_speed_valid) begin
                o_ctl.phase_nxt = PH_TIMEOUT;
                o_res.event_res = EV_TIMEOUT;
                o_res.phase_out = phase_code(PH_TIMEOUT);
            end else if (motion_hit) begin
                o_ctl.phase_nxt = PH_CONFIRMED;
                o_res.event_res = EV_MOTION;
                o_res.phase_out = phase_code(PH_CONFIRMED);
            end else if (timed_out) begin
                o_ctl.phase_nxt = PH_TIMEOUT;
                o_res.event_res = EV_TIMEOUT;
                o_res.phase_out = phase_code(PH_TIMEOUT);
            end else if (retry_due) begin
                o_ctl.load_last         = 1'b1;
                o_res.event_res         = EV_RETRY;
                o_res.send_request      = 1'b1;
                o_res.suppress_recovery = 1'b1;
            end else begin
                o_res.suppress_recovery = 1'b1;
            end
        end
    end

endmodule

[hdl/lerg_pipe.sv]
`include "launch_engage_retry_guard_unit_macros.svh"

module lerg_pipe #(
    parameter int TIME_WIDTH  = lerg_pkg::TIME_WIDTH_DEF,
    parameter int SPEED_WIDTH = lerg_pkg::SPEED_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lerg_pkg::t_cfg             i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_cmd,
    input  logic [1:0]                 i_state_kind,
    input  logic [TIME_WIDTH-1:0]      i_now_time,
    input  logic                       i_time_valid,
    input  logic signed [SPEED_WIDTH-1:0] i_speed,
    input  logic                       i_speed_valid,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lerg_pkg::t_result          o_res
);
    import lerg_pkg::*;

    // Input stage
    logic                   r_in_valid;
    t_cmd                   r_cmd;
    t_kind                  r_kind;
    logic [TIME_WIDTH-1:0]  r_now;
    logic                   r_time_valid;
    logic [SPEED_WIDTH-1:0] r_speed;
    logic                   r_speed_valid;

    // Guard state
    t_phase                 r_phase;
    logic [TIME_WIDTH-1:0]  r_start_time;
    logic [TIME_WIDTH-1:0]  r_last_time;

    // Result stage
    logic                   r_out_valid;
    t_result                r_res;

    t_ctl                   n_ctl;
    t_result                n_res;
    logic                   adv;
    logic                   in_xfer;

    // Input stage moves on when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd         <= t_cmd'(i_cmd);
            r_kind        <= t_kind'(i_state_kind);
            r_now         <= i_now_time;
            r_time_valid  <= i_time_valid;
            r_speed       <= i_speed;
            r_speed_valid <= i_speed_valid;
        end
    end

    lerg_decide #(
        .TIME_WIDTH  (TIME_WIDTH),
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_decide (
        .i_cfg         (i_cfg),
        .i_cmd         (r_cmd),
        .i_kind        (r_kind),
        .i_now         (r_now),
        .i_time_valid  (r_time_valid),
        .i_speed       (r_speed),
        .i_speed_valid (r_speed_valid),
        .i_phase       (r_phase),
        .i_start_time  (r_start_time),
        .i_last_time   (r_last_time),
        .o_ctl         (n_ctl),
        .o_res         (n_res)
    );

    // State commits with the item leaving the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_start_time <= '0;
            r_last_time  <= '0;
        end else if (adv) begin
            r_phase <= n_ctl.phase_nxt;
            if (n_ctl.clr_times) begin
                r_start_time <= '0;
                r_last_time  <= '0;
            end else begin
                if (n_ctl.load_start) r_start_time <= r_now;
                if (n_ctl.load_last)  r_last_time  <= r_now;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // A stalled result is never dropped
    `LERG_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> r_out_valid)
    // Requests only go out with a request event
    `LERG_ASSERT(a_send_ev, i_clk, i_rst_n, (r_out_valid && r_res.send_request) |-> (r_res.event_res == EV_READY || r_res.event_res == EV_START || r_res.event_res == EV_RETRY))
    // Suppression is only reported while awaiting motion
    `LERG_ASSERT(a_sup_phase, i_clk, i_rst_n, (r_out_valid && r_res.suppress_recovery) |-> (r_res.phase_out == phase_code(PH_AWAIT)))
    // A timeout result leaves the guard in the timed-out phase
    `LERG_ASSERT(a_timeout_state, i_clk, i_rst_n, (adv && n_res.event_res == EV_TIMEOUT) |=> (r_phase == PH_TIMEOUT))
    // Reported phase matches the stored phase while enabled
    `LERG_ASSERT(a_phase_match, i_clk, i_rst_n, (adv && i_cfg.guard_enable) |=> (r_res.phase_out == phase_code(r_phase)))

endmodule

[hdl/launch_engage_retry_guard_unit.sv]
// Launch engage retry guard.
// An item passes the input register, then the result register, before its result transfers.
// Throughput: one item per cycle unless stalled; state read and updated in one decision stage.
// A stalled result register holds one item while the input stage holds the next.
// Reset (i_rst_n low, synchronous): pipeline empty, phase idle, times zero, registers default.
module launch_engage_retry_guard_unit #(
    parameter int TIME_WIDTH  = lerg_pkg::TIME_WIDTH_DEF,
    parameter int SPEED_WIDTH = lerg_pkg::SPEED_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [lerg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lerg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [1:0]                     i_state_kind,
    input  logic [TIME_WIDTH-1:0]          i_now_time,
    input  logic                           i_time_valid,
    input  logic signed [SPEED_WIDTH-1:0]  i_speed,
    input  logic                           i_speed_valid,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_event_res,
    output logic                           o_send_request,
    output logic                           o_suppress_recovery,
    output logic [2:0]                     o_phase_out
);
    import lerg_pkg::*;

    t_cfg    cfg;
    t_result res;

    lerg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lerg_pipe #(
        .TIME_WIDTH  (TIME_WIDTH),
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_state_kind  (i_state_kind),
        .i_now_time    (i_now_time),
        .i_time_valid  (i_time_valid),
        .i_speed       (i_speed),
        .i_speed_valid (i_speed_valid),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_res         (res)
    );

    assign o_event_res         = res.event_res;
    assign o_send_request      = res.send_request;
    assign o_suppress_recovery = res.suppress_recovery;
    assign o_phase_out         = res.phase_out;

endmodule
